FILE: sv/mnp_pkg.sv
package mnp_pkg;

  // Fixed field widths of the event and note records.
  localparam int CHAN_W  = 4;
  localparam int PITCH_W = 7;
  localparam int VEL_W   = 7;
  localparam int TRACK_W = 5;
  localparam int KIND_W  = 2;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEF  = 16;
  localparam int PITCHES_DEF   = 128;
  localparam int TICK_BITS_DEF = 32;
  localparam int ID_BITS_DEF   = 16;

  // Item mode codes.
  localparam logic MODE_SONG  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Song event kinds; anything else only advances the largest tick.
  localparam logic [KIND_W-1:0] KIND_ON    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

endpackage

FILE: sv/mnp_key_store.sv
module mnp_key_store #(
  parameter int DEPTH   = 2048,
  parameter int ADDR_W  = 11,
  parameter int ENTRY_W = 61
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  output logic               busy
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               busy_r;
  logic               busy_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [ADDR_W-1:0]  clr_cnt_nxt;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  // After reset every entry is swept once to clear its open flag.
  always_comb begin
    busy_nxt    = busy_r;
    clr_cnt_nxt = clr_cnt_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign mem_we = busy_r | wr_en;
  assign mem_wa = busy_r ? clr_cnt_r : wr_addr;
  assign mem_wd = busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

FILE: sv/midi_note_pairing.sv
// An event is registered in the pairing stage, and the note record it closes is then registered
// in the output register, which drives out_valid.
// Throughput: one event beat per cycle while no note is held up at the output, set by one
// key-store read-modify-write per event; a matching key forwards the previous event's write.
// Reset: rst_n is synchronous and active low. After reset the key store is swept once over all
// CHANNELS*PITCHES entries (2048 by default), with in_ready low during the sweep.
module midi_note_pairing #(
  parameter int CHANNELS  = mnp_pkg::CHANNELS_DEF,
  parameter int PITCHES   = mnp_pkg::PITCHES_DEF,
  parameter int TICK_BITS = mnp_pkg::TICK_BITS_DEF,
  parameter int ID_BITS   = mnp_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [mnp_pkg::KIND_W-1:0]          in_event_kind,
  input  logic [TICK_BITS-1:0]                in_tick,
  input  logic [mnp_pkg::CHAN_W-1:0]          in_channel,
  input  logic [mnp_pkg::PITCH_W-1:0]         in_pitch,
  input  logic [mnp_pkg::VEL_W-1:0]           in_velocity,
  input  logic signed [mnp_pkg::TRACK_W-1:0]  in_track,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ID_BITS-1:0]                  out_note_id,
  output logic [TICK_BITS-1:0]                out_start_tick,
  output logic [TICK_BITS-1:0]                out_end_tick,
  output logic [mnp_pkg::PITCH_W-1:0]         out_note_pitch,
  output logic [mnp_pkg::CHAN_W-1:0]          out_note_channel,
  output logic [mnp_pkg::VEL_W-1:0]           out_note_velocity,
  output logic signed [mnp_pkg::TRACK_W-1:0]  out_note_track
);

  // One store entry per (channel, pitch) key. Entry layout, high to low:
  // open flag, note id, start tick, velocity, track.
  localparam int KEY_COUNT = CHANNELS * PITCHES;
  localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int ENTRY_W   = 1 + ID_BITS + TICK_BITS + mnp_pkg::VEL_W + mnp_pkg::TRACK_W;
  localparam int TRK_LO    = 0;
  localparam int VEL_LO    = TRK_LO + mnp_pkg::TRACK_W;
  localparam int START_LO  = VEL_LO + mnp_pkg::VEL_W;
  localparam int ID_LO     = START_LO + TICK_BITS;
  localparam int VALID_POS = ID_LO + ID_BITS;

  // Key decode for the incoming beat. The address is computed on a
  // 32-bit product and cut to the store's width; keys out of range never
  // get written to the store.
  logic [31:0]      in_key_full;
  logic [KEY_W-1:0] in_addr;
  logic             in_key_ok;
  logic             in_accept;

  assign in_key_full = 32'(in_channel) * 32'(PITCHES) + 32'(in_pitch);
  assign in_addr     = in_key_full[KEY_W-1:0];
  assign in_key_ok   = ({1'b0, in_channel} < (mnp_pkg::CHAN_W + 1)'(CHANNELS)) &&
                       ({1'b0, in_pitch} < (mnp_pkg::PITCH_W + 1)'(PITCHES));
  assign in_accept   = in_valid && in_ready;

  // Key store: synchronous read issued on the accept beat, data back
  // on the next cycle, when the event sits in the pairing stage.
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic               store_busy;

  // Pairing stage registers.
  logic                               s1_valid_r;
  logic                               s1_mode_r;
  logic [mnp_pkg::KIND_W-1:0]         s1_kind_r;
  logic [TICK_BITS-1:0]               s1_tick_r;
  logic [mnp_pkg::CHAN_W-1:0]         s1_ch_r;
  logic [mnp_pkg::PITCH_W-1:0]        s1_pitch_r;
  logic [mnp_pkg::VEL_W-1:0]          s1_vel_r;
  logic signed [mnp_pkg::TRACK_W-1:0] s1_trk_r;
  logic [KEY_W-1:0]                   s1_addr_r;
  logic                               s1_key_ok_r;

  // Forwarding: the write of the event ahead lands on the same edge the
  // next event's read is issued, so the read sees stale data. When the
  // keys match, the written entry is captured here and used instead.
  logic               fwd_hit_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  logic [ID_BITS-1:0]   next_id_r;
  logic [TICK_BITS-1:0] largest_tick_r;

  mnp_key_store #(
    .DEPTH   (KEY_COUNT),
    .ADDR_W  (KEY_W),
    .ENTRY_W (ENTRY_W)
  ) u_key_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .busy    (store_busy)
  );

  // Current entry for the event in the pairing stage.
  logic [ENTRY_W-1:0]                 ent;
  logic                               e_open;
  logic [ID_BITS-1:0]                 e_id;
  logic [TICK_BITS-1:0]               e_start;
  logic [mnp_pkg::VEL_W-1:0]          e_vel;
  logic signed [mnp_pkg::TRACK_W-1:0] e_trk;

  assign ent     = fwd_hit_r ? fwd_data_r : rd_data;
  assign e_open  = ent[VALID_POS];
  assign e_id    = ent[ID_LO +: ID_BITS];
  assign e_start = ent[START_LO +: TICK_BITS];
  assign e_vel   = ent[VEL_LO +: mnp_pkg::VEL_W];
  assign e_trk   = $signed(ent[TRK_LO +: mnp_pkg::TRACK_W]);

  logic                 is_flush;
  logic                 is_on;
  logic                 is_off;
  logic                 touches_key;
  logic                 has_result;
  logic [TICK_BITS-1:0] end_raw;
  logic [TICK_BITS-1:0] end_tick;
  logic                 out_free;
  logic                 s1_go;

  assign is_flush    = (s1_mode_r == mnp_pkg::MODE_FLUSH);
  assign is_on       = !is_flush && (s1_kind_r == mnp_pkg::KIND_ON);
  assign is_off      = !is_flush && (s1_kind_r == mnp_pkg::KIND_OFF);
  assign touches_key = s1_key_ok_r && (is_flush || is_on || is_off);

  // Every close of an open key yields one note. A flush closes at the
  // largest tick seen; the end never falls before the start.
  assign has_result = touches_key && e_open;
  assign end_raw    = is_flush ? largest_tick_r : s1_tick_r;
  assign end_tick   = (end_raw < e_start) ? e_start : end_raw;

  // The stage moves on unless its note has nowhere to go.
  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid_r && (!has_result || out_free);
  assign in_ready = !store_busy && (!s1_valid_r || s1_go);

  // A note on reopens the key with fresh data; off and flush leave it closed.
  assign wr_en   = s1_go && touches_key;
  assign wr_data = is_on ? {1'b1, next_id_r, s1_tick_r, s1_vel_r, s1_trk_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r   <= in_mode;
      s1_kind_r   <= in_event_kind;
      s1_tick_r   <= in_tick;
      s1_ch_r     <= in_channel;
      s1_pitch_r  <= in_pitch;
      s1_vel_r    <= in_velocity;
      s1_trk_r    <= in_track;
      s1_addr_r   <= in_addr;
      s1_key_ok_r <= in_key_ok;
      fwd_data_r  <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_accept) begin
      fwd_hit_r <= wr_en && (s1_addr_r == in_addr);
    end
  end

  // Id counter and largest tick advance in event order.
  logic [ID_BITS-1:0]   next_id_nxt;
  logic [TICK_BITS-1:0] largest_tick_nxt;

  always_comb begin
    next_id_nxt      = next_id_r;
    largest_tick_nxt = largest_tick_r;
    if (s1_go && s1_key_ok_r && is_on) begin
      next_id_nxt = next_id_r + 1'b1;
    end
    if (s1_go && !is_flush && (s1_tick_r > largest_tick_r)) begin
      largest_tick_nxt = s1_tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r      <= '0;
      largest_tick_r <= '0;
    end else begin
      next_id_r      <= next_id_nxt;
      largest_tick_r <= largest_tick_nxt;
    end
  end

  // Output register: parts the pairing stage from the consumer.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      out_note_id       <= e_id;
      out_start_tick    <= e_start;
      out_end_tick      <= end_tick;
      out_note_pitch    <= s1_pitch_r;
      out_note_channel  <= s1_ch_r;
      out_note_velocity <= e_vel;
      out_note_track    <= e_trk;
    end
  end

  assign out_valid = out_valid_r;

  // No event may be in flight while the store is being swept.
  a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    store_busy |-> (!s1_valid_r && !in_ready))
    else $error("event in flight during key store sweep");

  // A delivered note never ends before it starts.
  a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_end_tick >= out_start_tick))
    else $error("note end before start");

  // Each note on in range takes exactly the next id.
  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_key_ok_r && is_on) |=> (next_id_r == $past(next_id_r) + 1'b1))
    else $error("note id did not advance on note on");

  // The largest tick never falls outside reset.
  a_largest_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (largest_tick_r >= $past(largest_tick_r)))
    else $error("largest tick decreased");

endmodule
